// ----- design/smu3_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package smu3_pkg;

	// Default element width and width of the result value field
	localparam int ELEM_WIDTH_DEF = 8;
	localparam int VAL_W          = 25;

	// Operation codes carried by the mode field; the spare code does nothing
	typedef enum logic [2:0] {
		MODE_LOAD = 3'd0,
		MODE_ADD  = 3'd1,
		MODE_SUB  = 3'd2,
		MODE_MUL  = 3'd3,
		MODE_DET  = 3'd4,
		MODE_TRN  = 3'd5,
		MODE_HOM  = 3'd6,
		MODE_NONE = 3'd7
	} mode_t;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_CALC,
		S_EMIT
	} state_t;

	// Control of the shared multiply-accumulate unit
	typedef struct packed {
		logic p_load;    // load partial product with the element
		logic p_mul;     // partial product times element
		logic use_p;     // multiplier takes the partial product as first operand
		logic acc_en;    // accumulate the product
		logic acc_clear; // start a fresh sum
		logic acc_neg;   // subtract instead of add
	} mac_ctrl_t;

	// Row-major store index of element (r, c)
	function automatic logic [3:0] elem_idx(input logic [1:0] r, input logic [1:0] c);
		elem_idx = 4'({r, 1'b0}) + 4'(r) + 4'(c);
	endfunction

	// Element {row, col} of one factor of a Sarrus term; terms three to five are negative
	function automatic logic [3:0] det_rc(input logic [2:0] term, input logic [1:0] sub);
		logic [5:0] cols;
		logic [1:0] c;
		case (term)
			3'd0:    cols = 6'b00_01_10;
			3'd1:    cols = 6'b01_10_00;
			3'd2:    cols = 6'b10_00_01;
			3'd3:    cols = 6'b00_10_01;
			3'd4:    cols = 6'b01_00_10;
			3'd5:    cols = 6'b10_01_00;
			default: cols = 6'b00_01_10;
		endcase
		case (sub)
			2'd0:    c = cols[5:4];
			2'd1:    c = cols[3:2];
			default: c = cols[1:0];
		endcase
		det_rc = {sub, c};
	endfunction

endpackage

`default_nettype wire

// ----- design/smu3_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface smu3_in_if;
	logic              valid;
	logic              ready;
	logic [2:0]        mode;
	logic              matrix_select;
	logic [1:0]        row_index;
	logic [1:0]        col_index;
	logic signed [7:0] element_value;

	modport source (
		output valid, mode, matrix_select, row_index, col_index, element_value,
		input  ready
	);
	modport sink (
		input  valid, mode, matrix_select, row_index, col_index, element_value,
		output ready
	);
endinterface

`default_nettype wire

// ----- design/smu3_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface smu3_out_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       out_row;
	logic [1:0]                       out_col;
	logic signed [smu3_pkg::VAL_W-1:0] out_value;
	logic                             last;

	modport source (
		output valid, out_row, out_col, out_value, last,
		input  ready
	);
	modport sink (
		input  valid, out_row, out_col, out_value, last,
		output ready
	);
endinterface

`default_nettype wire

// ----- design/smu3_mac.sv -----
`timescale 1ns / 1ps
`default_nettype none

module smu3_mac #(
	parameter int ELEM_WIDTH = smu3_pkg::ELEM_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire smu3_pkg::mac_ctrl_t                ctrl,
	input  wire logic signed [ELEM_WIDTH-1:0]       x,
	input  wire logic signed [ELEM_WIDTH-1:0]       y,
	output logic signed [3*ELEM_WIDTH+2:0]          acc
);

	localparam int P_W    = 2 * ELEM_WIDTH;
	localparam int PROD_W = 3 * ELEM_WIDTH;
	localparam int ACC_W  = 3 * ELEM_WIDTH + 3;

	logic signed [P_W-1:0]    p_q;
	logic signed [P_W-1:0]    mul_x;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  base;

	// Pick first operand and form the single shared product
	assign mul_x = ctrl.use_p ? p_q : P_W'(x);
	assign prod  = PROD_W'(mul_x) * PROD_W'(y);
	assign base  = ctrl.acc_clear ? '0 : acc_q;

	// Hold partial product of a Sarrus term
	always_ff @(posedge clk) begin
		if (ctrl.p_load) begin
			p_q <= P_W'(y);
		end else if (ctrl.p_mul) begin
			p_q <= prod[P_W-1:0];
		end
	end

	// Accumulate or subtract the product
	always_ff @(posedge clk) begin
		if (ctrl.acc_en) begin
			if (ctrl.acc_neg) begin
				acc_q <= base - ACC_W'(prod);
			end else begin
				acc_q <= base + ACC_W'(prod);
			end
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

// ----- design/small_matrix_unit_3x3.sv -----
// Load: one item per cycle while idle, no result. Add, subtract, transpose: nine results at
// one a cycle unless the output stalls, homogeneous: sixteen; the first result is registered
// once the output register is free. Multiply: per element, three passes of the shared
// multiply-accumulate, then one emit. Determinant: six terms of three multiplier passes
// each, then one emit. A new item is taken only once the previous run has been handed to the
// output register. Asynchronous reset clears both matrix stores, sequencer and output valid.
`timescale 1ns / 1ps
`default_nettype none

module small_matrix_unit_3x3 #(
	parameter int ELEM_WIDTH = smu3_pkg::ELEM_WIDTH_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	smu3_in_if.sink     cmd,
	smu3_out_if.source  res
);

	localparam int ACC_W = 3 * ELEM_WIDTH + 3;
	localparam int EXT_W = ACC_W + smu3_pkg::VAL_W;
	localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'((64'sd1 <<< (smu3_pkg::VAL_W - 1)) - 1);
	localparam logic signed [EXT_W-1:0] SAT_LO = -SAT_HI - EXT_W'(1);

	smu3_pkg::state_t state_q, state_d;
	smu3_pkg::mac_ctrl_t mac_ctrl;

	logic [8:0][ELEM_WIDTH-1:0] a_q;
	logic [8:0][ELEM_WIDTH-1:0] b_q;

	logic [2:0] mode_q;
	logic       sel_q;
	logic [1:0] row_q, col_q, step_q;
	logic [2:0] term_q;

	logic        fire;
	logic [3:0]  wr_idx;
	logic [3:0]  ra, rb;
	logic [3:0]  ia, ib;
	logic [3:0]  det_pos;
	logic signed [ELEM_WIDTH-1:0] elem_a, elem_b, elem_s, mac_y;
	logic signed [ACC_W-1:0] acc;
	logic signed [ACC_W-1:0] simple_v, emit_v;
	logic signed [EXT_W-1:0] emit_ext;
	logic signed [smu3_pkg::VAL_W-1:0] sat_v;
	logic [1:0]  lim;
	logic        row_end, col_end, last_n, calc_mode;
	logic        slot_free, load_out;

	logic        out_valid_q;
	logic [1:0]  out_row_q, out_col_q;
	logic signed [smu3_pkg::VAL_W-1:0] out_value_q;
	logic        out_last_q;

	assign fire      = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == smu3_pkg::S_IDLE);
	assign wr_idx    = smu3_pkg::elem_idx(cmd.row_index, cmd.col_index);
	assign det_pos   = smu3_pkg::det_rc(term_q, step_q);
	assign calc_mode = (mode_q == smu3_pkg::MODE_MUL) || (mode_q == smu3_pkg::MODE_DET);

	// Write the matrix stores on a load transfer inside the matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0;
			b_q <= '0;
		end else if (fire && cmd.mode == smu3_pkg::MODE_LOAD &&
		             cmd.row_index != 2'd3 && cmd.col_index != 2'd3) begin
			if (cmd.matrix_select) begin
				b_q[wr_idx] <= ELEM_WIDTH'(cmd.element_value);
			end else begin
				a_q[wr_idx] <= ELEM_WIDTH'(cmd.element_value);
			end
		end
	end

	// Steer read addresses for the running operation
	always_comb begin
		unique case (mode_q) inside
			smu3_pkg::MODE_MUL: begin
				ra = {row_q, step_q};
				rb = {step_q, col_q};
			end
			smu3_pkg::MODE_DET: begin
				ra = det_pos;
				rb = det_pos;
			end
			smu3_pkg::MODE_TRN: begin
				ra = {col_q, row_q};
				rb = {col_q, row_q};
			end
			default: begin
				ra = {row_q, col_q};
				rb = {row_q, col_q};
			end
		endcase
	end

	// Read one element of each store; the added row and column read as zero
	always_comb begin
		ia = smu3_pkg::elem_idx(ra[3:2], ra[1:0]);
		ib = smu3_pkg::elem_idx(rb[3:2], rb[1:0]);
		elem_a = (ra[3:2] != 2'd3 && ra[1:0] != 2'd3) ? a_q[ia] : '0;
		elem_b = (rb[3:2] != 2'd3 && rb[1:0] != 2'd3) ? b_q[ib] : '0;
		elem_s = sel_q ? elem_b : elem_a;
		mac_y  = (mode_q == smu3_pkg::MODE_MUL) ? elem_b : elem_s;
	end

	smu3_mac #(
		.ELEM_WIDTH(ELEM_WIDTH)
	) u_mac (
		.clk  (clk),
		.ctrl (mac_ctrl),
		.x    (elem_a),
		.y    (mac_y),
		.acc  (acc)
	);

	// Form add, subtract and copy results, pick them or the accumulator, and saturate to the result field
	always_comb begin
		case (mode_q)
			smu3_pkg::MODE_ADD: simple_v = ACC_W'(elem_a) + ACC_W'(elem_b);
			smu3_pkg::MODE_SUB: simple_v = ACC_W'(elem_a) - ACC_W'(elem_b);
			smu3_pkg::MODE_HOM: begin
				if (row_q == 2'd3 && col_q == 2'd3) begin
					simple_v = ACC_W'(1);
				end else begin
					simple_v = ACC_W'(elem_s);
				end
			end
			default:            simple_v = ACC_W'(elem_s);
		endcase
		emit_v   = calc_mode ? acc : simple_v;
		emit_ext = EXT_W'(emit_v);
		if (emit_ext > SAT_HI) begin
			sat_v = SAT_HI[smu3_pkg::VAL_W-1:0];
		end else if (emit_ext < SAT_LO) begin
			sat_v = SAT_LO[smu3_pkg::VAL_W-1:0];
		end else begin
			sat_v = emit_ext[smu3_pkg::VAL_W-1:0];
		end
	end

	// Track position in the result grid
	always_comb begin
		lim     = (mode_q == smu3_pkg::MODE_HOM) ? 2'd3 : 2'd2;
		row_end = (row_q == lim);
		col_end = (col_q == lim);
		last_n  = (mode_q == smu3_pkg::MODE_DET) || (row_end && col_end);
	end

	assign slot_free = !out_valid_q || res.ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			smu3_pkg::S_IDLE: begin
				if (fire) begin
					unique case (cmd.mode) inside
						smu3_pkg::MODE_ADD, smu3_pkg::MODE_SUB,
						smu3_pkg::MODE_TRN, smu3_pkg::MODE_HOM: state_d = smu3_pkg::S_EMIT;
						smu3_pkg::MODE_MUL, smu3_pkg::MODE_DET: state_d = smu3_pkg::S_CALC;
						default:                                state_d = smu3_pkg::S_IDLE;
					endcase
				end
			end
			smu3_pkg::S_CALC: begin
				if (step_q == 2'd2 &&
				    (mode_q == smu3_pkg::MODE_MUL || term_q == 3'd5)) begin
					state_d = smu3_pkg::S_EMIT;
				end
			end
			smu3_pkg::S_EMIT: begin
				if (slot_free) begin
					if (last_n) begin
						state_d = smu3_pkg::S_IDLE;
					end else if (mode_q == smu3_pkg::MODE_MUL) begin
						state_d = smu3_pkg::S_CALC;
					end
				end
			end
			default: state_d = smu3_pkg::S_IDLE;
		endcase
	end

	// Sequencer outputs: multiply-accumulate control and output load
	always_comb begin
		mac_ctrl = '0;
		load_out = 1'b0;
		unique case (state_q)
			smu3_pkg::S_CALC: begin
				if (mode_q == smu3_pkg::MODE_MUL) begin
					mac_ctrl.acc_en    = 1'b1;
					mac_ctrl.acc_clear = (step_q == 2'd0);
				end else begin
					mac_ctrl.p_load    = (step_q == 2'd0);
					mac_ctrl.p_mul     = (step_q == 2'd1);
					mac_ctrl.use_p     = (step_q != 2'd0);
					mac_ctrl.acc_en    = (step_q == 2'd2);
					mac_ctrl.acc_clear = (term_q == 3'd0);
					mac_ctrl.acc_neg   = (term_q >= 3'd3);
				end
			end
			smu3_pkg::S_EMIT: load_out = slot_free;
			default: ;
		endcase
	end

	// Advance state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smu3_pkg::S_IDLE;
			mode_q  <= smu3_pkg::MODE_LOAD;
			sel_q   <= 1'b0;
			row_q   <= 2'd0;
			col_q   <= 2'd0;
			step_q  <= 2'd0;
			term_q  <= 3'd0;
		end else begin
			state_q <= state_d;
			if (fire) begin
				mode_q <= cmd.mode;
				sel_q  <= cmd.matrix_select;
				row_q  <= 2'd0;
				col_q  <= 2'd0;
				step_q <= 2'd0;
				term_q <= 3'd0;
			end else if (state_q == smu3_pkg::S_CALC) begin
				if (step_q == 2'd2) begin
					step_q <= 2'd0;
					term_q <= term_q + 3'd1;
				end else begin
					step_q <= step_q + 2'd1;
				end
			end else if (load_out && !last_n) begin
				step_q <= 2'd0;
				if (col_end) begin
					col_q <= 2'd0;
					row_q <= row_q + 2'd1;
				end else begin
					col_q <= col_q + 2'd1;
				end
			end
		end
	end

	// Hold output valid until the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Capture result payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_row_q   <= row_q;
			out_col_q   <= col_q;
			out_value_q <= sat_v;
			out_last_q  <= last_n;
		end
	end

	assign res.valid     = out_valid_q;
	assign res.out_row   = out_row_q;
	assign res.out_col   = out_col_q;
	assign res.out_value = out_value_q;
	assign res.last      = out_last_q;

	// An operation transfer makes the block busy
	a_busy_after_op: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cmd.mode != smu3_pkg::MODE_LOAD && cmd.mode != smu3_pkg::MODE_NONE
		|=> !cmd.ready)
		else $error("block ready right after taking an operation");

	// Stores change only on a load transfer
	a_store_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire && cmd.mode == smu3_pkg::MODE_LOAD) |=> $stable(a_q) && $stable(b_q))
		else $error("matrix store changed without a load");

	// Inner step never passes the third factor
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == smu3_pkg::S_CALC |-> step_q != 2'd3)
		else $error("multiply step out of range");

	// The final result of a run returns the sequencer to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && last_n |=> state_q == smu3_pkg::S_IDLE)
		else $error("sequencer busy after final result");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;

	localparam int MAX_SHOWN = 10;

	typedef struct {
		logic [1:0]                        row;
		logic [1:0]                        col;
		logic signed [smu3_pkg::VAL_W-1:0] value;
		logic                              last;
	} mat_result_t;

	// Shadow copy of both matrix stores and the queue of result elements still owed
	class matrix_scoreboard;
		logic signed [7:0] store_a[9];
		logic signed [7:0] store_b[9];
		mat_result_t       expected_elems[$];
		int                mismatches;

		function new();
			for (int k = 0; k < 9; k++) begin
				store_a[k] = '0;
				store_b[k] = '0;
			end
			mismatches = 0;
		endfunction

		function longint elem_at(bit sel, int r, int c);
			return sel ? longint'(store_b[r * 3 + c]) : longint'(store_a[r * 3 + c]);
		endfunction

		// Clamp to the result field and queue one element
		function void owe(int r, int c, longint v, bit last);
			longint hi;
			longint lo;
			mat_result_t e;
			hi = (longint'(1) <<< (smu3_pkg::VAL_W - 1)) - 1;
			lo = -hi - 1;
			if (v > hi)
				v = hi;
			if (v < lo)
				v = lo;
			e.row   = r[1:0];
			e.col   = c[1:0];
			e.value = v[smu3_pkg::VAL_W-1:0];
			e.last  = last;
			expected_elems.push_back(e);
		endfunction

		function longint sarrus(bit s);
			return elem_at(s, 0, 0) * elem_at(s, 1, 1) * elem_at(s, 2, 2)
			     + elem_at(s, 0, 1) * elem_at(s, 1, 2) * elem_at(s, 2, 0)
			     + elem_at(s, 0, 2) * elem_at(s, 1, 0) * elem_at(s, 2, 1)
			     - elem_at(s, 0, 0) * elem_at(s, 1, 2) * elem_at(s, 2, 1)
			     - elem_at(s, 0, 1) * elem_at(s, 1, 0) * elem_at(s, 2, 2)
			     - elem_at(s, 0, 2) * elem_at(s, 1, 1) * elem_at(s, 2, 0);
		endfunction

		// Update the shadow stores or queue the results of one accepted command
		function void note_transfer(logic [2:0] mode, logic sel, logic [1:0] r, logic [1:0] c,
				logic signed [7:0] v);
			int n;
			longint x;
			n = 0;
			case (mode) inside
				smu3_pkg::MODE_LOAD: begin
					if (r < 2'd3 && c < 2'd3) begin
						if (sel)
							store_b[r * 3 + c] = v;
						else
							store_a[r * 3 + c] = v;
					end
				end
				smu3_pkg::MODE_DET: owe(0, 0, sarrus(sel), 1'b1);
				smu3_pkg::MODE_HOM: begin
					for (int i = 0; i < 4; i++)
						for (int j = 0; j < 4; j++) begin
							if (i == 3 && j == 3)
								x = 1;
							else if (i == 3 || j == 3)
								x = 0;
							else
								x = elem_at(sel, i, j);
							owe(i, j, x, n == 15);
							n++;
						end
				end
				smu3_pkg::MODE_ADD, smu3_pkg::MODE_SUB,
				smu3_pkg::MODE_MUL, smu3_pkg::MODE_TRN: begin
					for (int i = 0; i < 3; i++)
						for (int j = 0; j < 3; j++) begin
							if (mode == smu3_pkg::MODE_ADD)
								x = elem_at(0, i, j) + elem_at(1, i, j);
							else if (mode == smu3_pkg::MODE_SUB)
								x = elem_at(0, i, j) - elem_at(1, i, j);
							else if (mode == smu3_pkg::MODE_MUL)
								x = elem_at(0, i, 0) * elem_at(1, 0, j)
								  + elem_at(0, i, 1) * elem_at(1, 1, j)
								  + elem_at(0, i, 2) * elem_at(1, 2, j);
							else
								x = elem_at(sel, j, i);
							owe(i, j, x, n == 8);
							n++;
						end
				end
				default: ;
			endcase
		endfunction

		// Compare one result transfer with the oldest element owed
		function void check_result(logic [1:0] row, logic [1:0] col,
				logic signed [smu3_pkg::VAL_W-1:0] value, logic last);
			mat_result_t e;
			if (expected_elems.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("%0t: unexpected result row %0d col %0d value %0d last %0b",
						$realtime, row, col, value, last);
				return;
			end
			e = expected_elems.pop_front();
			if (row !== e.row || col !== e.col || value !== e.value || last !== e.last) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("%0t: expected (%0d,%0d) %0d last %0b, got (%0d,%0d) %0d last %0b",
						$realtime, e.row, e.col, e.value, e.last, row, col, value, last);
			end
		endfunction

		function int pending();
			return expected_elems.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   idle_pct;
	int   stall_pct;
	matrix_scoreboard sb;

	smu3_in_if  cmd_if ();
	smu3_out_if res_if ();

	small_matrix_unit_3x3 dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.res    (res_if)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Drop result ready at random while a stall phase runs
	always @(negedge clk) begin
		res_if.ready = ($urandom_range(99) >= stall_pct);
	end

	// Check every result transfer
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			sb.check_result(res_if.out_row, res_if.out_col, res_if.out_value, res_if.last);
	end

	// Present one command, with random idle cycles first, and hold it until the transfer
	task automatic send_cmd(input logic [2:0] mode, input logic sel, input logic [1:0] r,
			input logic [1:0] c, input logic signed [7:0] v);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			cmd_if.valid = 1'b0;
			@(negedge clk);
		end
		cmd_if.valid         = 1'b1;
		cmd_if.mode          = mode;
		cmd_if.matrix_select = sel;
		cmd_if.row_index     = r;
		cmd_if.col_index     = c;
		cmd_if.element_value = v;
		@(posedge clk);
		while (!cmd_if.ready)
			@(posedge clk);
		sb.note_transfer(mode, sel, r, c, v);
	endtask

	// Hold off the sender until every owed result has arrived
	task automatic drain();
		@(negedge clk);
		cmd_if.valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [7:0] rand_elem();
		case ($urandom_range(9))
			0:       return -8'sd128;
			1:       return 8'sd127;
			2:       return 8'sd0;
			3:       return -8'sd1;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [1:0] rand_index();
		return ($urandom_range(7) == 0) ? 2'd3 : 2'($urandom_range(2));
	endfunction

	function automatic logic [2:0] rand_op();
		return 3'($urandom_range(smu3_pkg::MODE_HOM, smu3_pkg::MODE_ADD));
	endfunction

	// Random traffic: whole-matrix fills then an operation, single loads, bare ops, spare codes
	task automatic run_phase(input int n_items);
		int done;
		logic sel;
		logic [1:0] r;
		logic [1:0] c;
		done = 0;
		while (done < n_items) begin
			sel = 1'($urandom);
			case ($urandom_range(9))
				0, 1: begin
					for (int k = 0; k < 9; k++)
						send_cmd(smu3_pkg::MODE_LOAD, sel, 2'(k / 3), 2'(k % 3), rand_elem());
					send_cmd(rand_op(), 1'($urandom), 2'($urandom), 2'($urandom), 8'($urandom));
					done += 10;
				end
				2, 3, 4, 5: begin
					r = rand_index();
					c = rand_index();
					send_cmd(smu3_pkg::MODE_LOAD, sel, r, c, rand_elem());
					done++;
				end
				6, 7, 8: begin
					send_cmd(rand_op(), sel, 2'($urandom), 2'($urandom), 8'($urandom));
					done++;
				end
				default: begin
					send_cmd(smu3_pkg::MODE_NONE, sel, 2'($urandom), 2'($urandom),
						8'($urandom));
					done++;
				end
			endcase
		end
	endtask

	initial begin
		sb                   = new();
		idle_pct             = 0;
		stall_pct            = 0;
		arst_n               = 1'b0;
		cmd_if.valid         = 1'b0;
		cmd_if.mode          = smu3_pkg::MODE_LOAD;
		cmd_if.matrix_select = 1'b0;
		cmd_if.row_index     = 2'd0;
		cmd_if.col_index     = 2'd0;
		cmd_if.element_value = 8'sd0;
		res_if.ready         = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Cleared stores first, then extremes and ignored writes, then every operation
		send_cmd(smu3_pkg::MODE_DET, 1'b0, 2'd0, 2'd0, 8'sd0);
		send_cmd(smu3_pkg::MODE_HOM, 1'b1, 2'd0, 2'd0, 8'sd0);
		for (int k = 0; k < 3; k++)
			send_cmd(smu3_pkg::MODE_LOAD, 1'b0, 2'(k), 2'(k), -8'sd128);
		send_cmd(smu3_pkg::MODE_LOAD, 1'b0, 2'd0, 2'd2, 8'sd127);
		send_cmd(smu3_pkg::MODE_LOAD, 1'b0, 2'd1, 2'd0, 8'sd127);
		send_cmd(smu3_pkg::MODE_LOAD, 1'b0, 2'd2, 2'd1, 8'sd127);
		send_cmd(smu3_pkg::MODE_LOAD, 1'b1, 2'd0, 2'd0, 8'sd127);
		send_cmd(smu3_pkg::MODE_LOAD, 1'b1, 2'd2, 2'd2, -8'sd1);
		send_cmd(smu3_pkg::MODE_LOAD, 1'b1, 2'd1, 2'd2, -8'sd128);
		send_cmd(smu3_pkg::MODE_LOAD, 1'b0, 2'd3, 2'd0, 8'sd55);
		send_cmd(smu3_pkg::MODE_LOAD, 1'b1, 2'd1, 2'd3, -8'sd86);
		send_cmd(smu3_pkg::MODE_LOAD, 1'b1, 2'd3, 2'd3, 8'sd1);
		send_cmd(smu3_pkg::MODE_NONE, 1'b1, 2'd3, 2'd3, -8'sd1);
		send_cmd(smu3_pkg::MODE_ADD, 1'b0, 2'd0, 2'd0, 8'sd0);
		send_cmd(smu3_pkg::MODE_SUB, 1'b1, 2'd0, 2'd0, 8'sd0);
		send_cmd(smu3_pkg::MODE_MUL, 1'b0, 2'd0, 2'd0, 8'sd0);
		send_cmd(smu3_pkg::MODE_DET, 1'b0, 2'd0, 2'd0, 8'sd0);
		send_cmd(smu3_pkg::MODE_DET, 1'b1, 2'd0, 2'd0, 8'sd0);
		send_cmd(smu3_pkg::MODE_TRN, 1'b0, 2'd0, 2'd0, 8'sd0);
		send_cmd(smu3_pkg::MODE_TRN, 1'b1, 2'd0, 2'd0, 8'sd0);
		send_cmd(smu3_pkg::MODE_HOM, 1'b0, 2'd0, 2'd0, 8'sd0);
		drain();

		// Random traffic under each idling and stalling pattern
		run_phase(20);
		drain();
		idle_pct = 68;
		run_phase(20);
		drain();
		idle_pct  = 0;
		stall_pct = 68;
		run_phase(20);
		drain();
		idle_pct  = 25;
		stall_pct = 25;
		run_phase(20);
		drain();

		// Catch any stray result after the last one owed
		repeat (60) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("small_matrix_unit_3x3 verification clean");
		end else begin
			$display("small_matrix_unit_3x3 verification failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#400000;
		$display("small_matrix_unit_3x3 verification failed");
		$finish;
	end

endmodule
